/* hw/rtl/csvfp_pkg.sv */
// Package for the CSV field parser: request and result payload types,
// queue command and status types, parser phase enum and code constants.
// No dependencies.
package csvfp_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } csvfp_in_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [1:0] terminator;
        logic       was_quoted;
        logic       stray_quote;
        logic       last;
    } csvfp_out_t;

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic       kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] terminator;
        logic       was_quoted;
        logic       stray;
        logic       two;
    } csvfp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } csvfp_q_status_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_RAW   = 2'd1,
        PH_STR   = 2'd2,
        PH_STRX  = 2'd3
    } csvfp_phase_t;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic       ACT_DATA  = 1'b0;
    localparam logic       ACT_EOI   = 1'b1;

    localparam logic [1:0] TERM_FIELD  = 2'd0;
    localparam logic [1:0] TERM_RECORD = 2'd1;
    localparam logic [1:0] TERM_EOI    = 2'd2;

    localparam logic [1:0] CFG_FIELD_SEP  = 2'd0;
    localparam logic [1:0] CFG_RECORD_SEP = 2'd1;
    localparam logic [1:0] CFG_QUOTE_CHAR = 2'd2;

    localparam logic [7:0] FIELD_SEP_RST  = 8'd44;
    localparam logic [7:0] RECORD_SEP_RST = 8'd10;
    localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;

endpackage

/* hw/rtl/csvfp_front.sv */
// Front end of the CSV field parser: configuration registers, parser
// phase state and classification of each request into a queue command.
// Depends on csvfp_pkg.
module csvfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  csvfp_pkg::csvfp_in_t in_data,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 q_full,
    output logic                 push,
    output csvfp_pkg::csvfp_cmd_t push_cmd
);
    import csvfp_pkg::*;

    logic [7:0]   field_sep_reg;
    logic [7:0]   record_sep_reg;
    logic [7:0]   quote_char_reg;
    csvfp_phase_t phase_reg, phase_next;
    logic         quoted_reg, quoted_next;
    logic         has_cmd;
    logic         accept;
    logic [7:0]   c;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && has_cmd;
    assign c        = in_data.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_sep_reg  <= FIELD_SEP_RST;
            record_sep_reg <= RECORD_SEP_RST;
            quote_char_reg <= QUOTE_CHAR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIELD_SEP:  field_sep_reg  <= cfg_data;
                CFG_RECORD_SEP: record_sep_reg <= cfg_data;
                CFG_QUOTE_CHAR: quote_char_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            quoted_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            quoted_reg <= quoted_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        has_cmd     = 1'b0;
        push_cmd    = '0;
        push_cmd.kind  = KIND_BYTE;
        push_cmd.byte0 = c;
        priority if (in_data.action == ACT_EOI)
        begin
            has_cmd             = 1'b1;
            push_cmd.kind       = KIND_END;
            push_cmd.byte0      = 8'd0;
            push_cmd.terminator = TERM_EOI;
            push_cmd.was_quoted = quoted_reg;
            phase_next          = PH_START;
            quoted_next         = 1'b0;
        end
        else if (c == quote_char_reg)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    phase_next  = PH_STR;
                    quoted_next = 1'b1;
                end
                PH_STR:  phase_next = PH_STRX;
                PH_RAW:  has_cmd = 1'b1;
                PH_STRX:
                begin
                    phase_next = PH_STR;
                    has_cmd    = 1'b1;
                end
                default: ;
            endcase
        end
        else if (c == field_sep_reg || c == record_sep_reg)
        begin
            has_cmd = 1'b1;
            if (phase_reg != PH_STR)
            begin
                push_cmd.kind       = KIND_END;
                push_cmd.byte0      = 8'd0;
                push_cmd.terminator = (c == field_sep_reg) ? TERM_FIELD : TERM_RECORD;
                push_cmd.was_quoted = quoted_reg;
                phase_next          = PH_START;
                quoted_next         = 1'b0;
            end
        end
        else
        begin
            has_cmd = 1'b1;
            if (phase_reg == PH_STRX)
            begin
                // The quote was not an escape: emit it and this byte, flagged.
                push_cmd.byte0 = quote_char_reg;
                push_cmd.byte1 = c;
                push_cmd.stray = 1'b1;
                push_cmd.two   = 1'b1;
                phase_next     = PH_STR;
            end
            else if (phase_reg == PH_START)
            begin
                phase_next = PH_RAW;
            end
        end
    end

endmodule

/* hw/rtl/csvfp_queue.sv */
// Short command queue between the parser front and the result back end.
// Register based; one write and one read pointer. Depends on csvfp_pkg.
module csvfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  csvfp_pkg::csvfp_cmd_t     push_cmd,
    input  logic                      pop,
    output csvfp_pkg::csvfp_cmd_t     pop_cmd,
    output csvfp_pkg::csvfp_q_status_t status
);
    import csvfp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    csvfp_cmd_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/csvfp_back.sv */
// Back end of the CSV field parser: turns queue commands into one or two
// results and holds them in the output register. Depends on csvfp_pkg.
module csvfp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csvfp_pkg::csvfp_q_status_t q_status,
    input  csvfp_pkg::csvfp_cmd_t     pop_cmd,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output csvfp_pkg::csvfp_out_t     out_data
);
    import csvfp_pkg::*;

    logic       out_valid_reg;
    csvfp_out_t out_reg;
    logic       half_reg;
    logic [7:0] second_byte_reg;
    logic       load;

    assign load      = !out_valid_reg || out_ready;
    assign pop       = load && !half_reg && !q_status.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else if (load)
        begin
            if (half_reg)
            begin
                out_valid_reg <= 1'b1;
                half_reg      <= 1'b0;
            end
            else
            begin
                out_valid_reg <= !q_status.empty;
                half_reg      <= !q_status.empty && pop_cmd.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (half_reg)
            begin
                out_reg.kind        <= KIND_BYTE;
                out_reg.out_byte    <= second_byte_reg;
                out_reg.terminator  <= TERM_FIELD;
                out_reg.was_quoted  <= 1'b0;
                out_reg.stray_quote <= 1'b1;
                out_reg.last        <= 1'b1;
            end
            else
            begin
                out_reg.kind        <= pop_cmd.kind;
                out_reg.out_byte    <= pop_cmd.byte0;
                out_reg.terminator  <= pop_cmd.terminator;
                out_reg.was_quoted  <= pop_cmd.was_quoted;
                out_reg.stray_quote <= pop_cmd.stray;
                out_reg.last        <= !pop_cmd.two;
                second_byte_reg     <= pop_cmd.byte1;
            end
        end
    end

endmodule

/* hw/rtl/csv_field_parser_unit.sv */
// Top level of the CSV field parser: front end, command queue, back end.
// Depends on csvfp_pkg, csvfp_front, csvfp_queue and csvfp_back.
//
// The unit splits a CSV byte stream into fields at one input request per
// clock cycle. Each request is a data byte or an end-of-input mark. The
// front end updates the parser phase and quoted flag in the cycle the
// request is accepted and writes a command into a queue of QUEUE_DEPTH
// entries; requests that open or close a quote produce nothing. The back
// end drains the queue into a registered output, so the first result of a
// request is registered after its command leaves the queue entry. Most
// requests give one result per cycle unless the output stalls; a stray
// quote inside a quoted field gives two results (the quote and the byte
// after it, both flagged) in turn, the queue holding later commands. Input
// ready drops only while the queue is full. Configuration writes are
// always accepted (cfg_ready is tied high); index values beyond the three
// registers are ignored. The block must be idle when reconfigured. There
// is no clearing pass after reset.
module csv_field_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  csvfp_pkg::csvfp_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output csvfp_pkg::csvfp_out_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import csvfp_pkg::*;

    csvfp_cmd_t      push_cmd;
    csvfp_cmd_t      pop_cmd;
    csvfp_q_status_t q_status;
    logic            push;
    logic            pop;

    // Registers are plain flops, so a write can land in any cycle.
    assign cfg_ready = 1'b1;

    csvfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_status.full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    csvfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    csvfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* hw/rtl/csvfp_checker.sv */
// Port-level checks for the CSV field parser, bound to the top level.
// Depends on csvfp_pkg and csv_field_parser_unit.
module csvfp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input csvfp_pkg::csvfp_out_t out_data
);
    import csvfp_pkg::*;

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A field end carries no byte and is always the only result.
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_END |->
            out_data.out_byte == 8'd0 && out_data.last && !out_data.stray_quote)
        else $error("malformed field end");

    // Only the stray-quote case produces a first result that is not last.
    a_first_is_stray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |->
            out_data.stray_quote && out_data.kind == KIND_BYTE)
        else $error("non-last result outside stray quote");

    // The stray byte follows its quote in the very next cycle.
    a_stray_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.stray_quote && !out_data.last |=>
            out_valid && out_data.stray_quote && out_data.last)
        else $error("stray quote not followed by its byte");

endmodule

bind csv_field_parser_unit csvfp_checker u_csvfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
